// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle check, sampled on clk, idle during reset
`define LLRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llrl check failed");

// Next-cycle check, sampled on clk, idle during reset
`define LLRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llrl check failed");

`endif

// ===== rtl/llrl_pkg.sv =====
`timescale 1ns / 1ps
package llrl_pkg;

  localparam int unsigned LVL_W      = 4;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned BURST_W    = 8;
  localparam int unsigned CAP_W      = INTERVAL_W + BURST_W;
  localparam int unsigned TOKEN_W    = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LVL_W-1:0]      HOST_LOWER_RST  = 4'd2;
  localparam logic [LVL_W-1:0]      HOST_UPPER_RST  = 4'd2;
  localparam logic [LVL_W-1:0]      GUEST_LOWER_RST = 4'd0;
  localparam logic [LVL_W-1:0]      GUEST_UPPER_RST = 4'd2;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 16'd5000;
  localparam logic [BURST_W-1:0]    BURST_RST       = 8'd10;
  localparam logic [CAP_W-1:0]      CAP_RST         = 24'd50000;
  localparam logic [TOKEN_W-1:0]    TOKENS_RST      = 32'd50000;
  localparam logic [COUNT_W-1:0]    DROPPED_MAX     = 16'hFFFF;
  localparam logic [1:0]            DEFAULT_LEVEL   = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOST_LOWER  = 3'd0,
    REG_HOST_UPPER  = 3'd1,
    REG_GUEST_LOWER = 3'd2,
    REG_GUEST_UPPER = 3'd3,
    REG_INTERVAL    = 3'd4,
    REG_BURST       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LVL_W-1:0]      host_lower;
    logic [LVL_W-1:0]      host_upper;
    logic [LVL_W-1:0]      guest_lower;
    logic [LVL_W-1:0]      guest_upper;
    logic [INTERVAL_W-1:0] interval;
    logic [CAP_W-1:0]      cap;
  } cfg_t;

  typedef struct packed {
    logic              from_guest;
    logic              has_level;
    logic [1:0]        level;
    logic              force_all;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic               allow;
    logic [COUNT_W-1:0] suppressed_count;
  } result_t;

endpackage

// ===== rtl/llrl_cfg.sv =====
`timescale 1ns / 1ps
module llrl_cfg import llrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [LVL_W-1:0]      host_lower_r, host_upper_r, guest_lower_r, guest_upper_r;
  logic [LVL_W-1:0]      host_lower_nxt, host_upper_nxt, guest_lower_nxt, guest_upper_nxt;
  logic [INTERVAL_W-1:0] interval_r, interval_nxt;
  logic [BURST_W-1:0]    burst_r, burst_nxt;
  logic [CAP_W-1:0]      cap_r;

  always_comb begin
    host_lower_nxt  = host_lower_r;
    host_upper_nxt  = host_upper_r;
    guest_lower_nxt = guest_lower_r;
    guest_upper_nxt = guest_upper_r;
    interval_nxt    = interval_r;
    burst_nxt       = burst_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_HOST_LOWER:  host_lower_nxt  = cfg_wdata[LVL_W-1:0];
        REG_HOST_UPPER:  host_upper_nxt  = cfg_wdata[LVL_W-1:0];
        REG_GUEST_LOWER: guest_lower_nxt = cfg_wdata[LVL_W-1:0];
        REG_GUEST_UPPER: guest_upper_nxt = cfg_wdata[LVL_W-1:0];
        REG_INTERVAL:    interval_nxt    = cfg_wdata[INTERVAL_W-1:0];
        REG_BURST:       burst_nxt       = cfg_wdata[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_lower_r  <= HOST_LOWER_RST;
      host_upper_r  <= HOST_UPPER_RST;
      guest_lower_r <= GUEST_LOWER_RST;
      guest_upper_r <= GUEST_UPPER_RST;
      interval_r    <= INTERVAL_RST;
      burst_r       <= BURST_RST;
      cap_r         <= CAP_RST;
    end else begin
      host_lower_r  <= host_lower_nxt;
      host_upper_r  <= host_upper_nxt;
      guest_lower_r <= guest_lower_nxt;
      guest_upper_r <= guest_upper_nxt;
      interval_r    <= interval_nxt;
      burst_r       <= burst_nxt;
      // cap built from the values being written, so it updates with them
      cap_r         <= CAP_W'(burst_nxt) * CAP_W'(interval_nxt);
    end
  end

  assign cfg.host_lower  = host_lower_r;
  assign cfg.host_upper  = host_upper_r;
  assign cfg.guest_lower = guest_lower_r;
  assign cfg.guest_upper = guest_upper_r;
  assign cfg.interval    = interval_r;
  assign cfg.cap         = cap_r;

endmodule

// ===== rtl/llrl_bucket.sv =====
`timescale 1ns / 1ps
module llrl_bucket import llrl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  req_t    req,
  input  cfg_t    cfg,
  output result_t res
);

  logic [TOKEN_W-1:0] tokens_r, tokens_nxt;
  logic [TIME_W-1:0]  last_r;
  logic [COUNT_W-1:0] dropped_r, dropped_nxt;

  logic [1:0]         lvl;
  logic [LVL_W-1:0]   lower, upper;
  logic               pass_low, band;
  logic [TIME_W-1:0]  elapsed;
  logic [TOKEN_W:0]   sum;
  logic [TOKEN_W-1:0] sat, capped, cap_ext, intv_ext;
  logic               bucket_ok;

  always_comb begin
    lvl      = req.has_level ? req.level : DEFAULT_LEVEL;
    lower    = req.from_guest ? cfg.guest_lower : cfg.host_lower;
    upper    = req.from_guest ? cfg.guest_upper : cfg.host_upper;
    pass_low = req.force_all || ({{(LVL_W-2){1'b0}}, lvl} < lower);
    band     = !pass_low && ({{(LVL_W-2){1'b0}}, lvl} < upper);

    // refill with wrapped elapsed time, saturate, then cap
    elapsed   = req.now_ms - last_r;
    sum       = {1'b0, tokens_r} + {1'b0, elapsed};
    sat       = sum[TOKEN_W] ? '1 : sum[TOKEN_W-1:0];
    cap_ext   = TOKEN_W'(cfg.cap);
    intv_ext  = TOKEN_W'(cfg.interval);
    capped    = (sat > cap_ext) ? cap_ext : sat;
    bucket_ok = (capped >= intv_ext);

    tokens_nxt  = bucket_ok ? (capped - intv_ext) : capped;
    dropped_nxt = bucket_ok ? '0 :
                  ((dropped_r == DROPPED_MAX) ? dropped_r : dropped_r + 1'b1);

    res.allow            = pass_low || (band && bucket_ok);
    res.suppressed_count = (band && bucket_ok) ? dropped_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tokens_r  <= TOKENS_RST;
      last_r    <= '0;
      dropped_r <= '0;
    end else if (fire && band) begin
      tokens_r  <= tokens_nxt;
      last_r    <= req.now_ms;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

// ===== rtl/log_level_rate_limiter_top.sv =====
`timescale 1ns / 1ps
// Log level rate limiter: decides per log message whether it is printed.
// Input channel (in_*): one message request per handshake carrying source,
// optional level, force flag and the current millisecond time.
// Output channel (out_*): one result per request, in order: allow and the
// number of band messages suppressed since the last bucket pass.
// Config port (cfg_*): writes of thresholds, interval and burst; the user must
// write only while no request is in flight; the block does not enforce it.
// An accepted request goes from the input register to the output register.
// Throughput: one request per cycle unless out_ready stalls; the bucket
// refill/cap/spend is done combinationally between the input and output
// registers, so back-to-back requests see each other's bucket state.
// Reset: thresholds 2/2 (host) and 0/2 (guest), interval 5000, burst 10,
// bucket holds 50000 tokens, last time 0, suppressed count 0; pipeline empty.
// Stall: when out_ready is low the output register holds its result, the
// input register fills, and in_ready then drops until the receiver drains.
module log_level_rate_limiter_top import llrl_pkg::*; #(
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_from_guest,
  input  logic                  in_has_level,
  input  logic [1:0]            in_level,
  input  logic                  in_force_all,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_allow,
  output logic [COUNT_W-1:0]    out_suppressed_count,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  cfg_t    cfg;
  req_t    s1_req_r;
  logic    s1_valid_r;
  result_t res, out_res_r;
  logic    out_valid_r;
  logic    adv;

  llrl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // output register free or draining this cycle
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  llrl_bucket u_bucket (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_valid_r && adv),
    .req   (s1_req_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r.from_guest <= in_from_guest;
      s1_req_r.has_level  <= in_has_level;
      s1_req_r.level      <= in_level;
      s1_req_r.force_all  <= in_force_all;
      s1_req_r.now_ms     <= in_now_ms;
    end
    if (adv && s1_valid_r) out_res_r <= res;
  end

  assign out_valid            = out_valid_r;
  assign out_allow            = out_res_r.allow;
  assign out_suppressed_count = out_res_r.suppressed_count;

  `LLRL_ASSERT_NOW(a_count_only_on_pass, out_valid_r && (out_suppressed_count != '0), out_allow)
  `LLRL_ASSERT_NOW(a_ready_when_out_empty, !out_valid_r, in_ready)
  `LLRL_ASSERT_NEXT(a_stage_held_on_stall, s1_valid_r && out_valid_r && !out_ready, s1_valid_r)

endmodule

// ===== test/tb_log_level_rate_limiter_top.sv =====
`timescale 1ns / 1ps
module tb_log_level_rate_limiter_top import llrl_pkg::*; ();

  localparam int WATCHDOG = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_MSGS = 65;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    req_t                  msg;
    bit                    typed;
    result_t               want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_from_guest = 1'b0;
  logic                  in_has_level = 1'b0;
  logic [1:0]            in_level = 2'd0;
  logic                  in_force_all = 1'b0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_allow;
  logic [COUNT_W-1:0]    out_suppressed_count;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // limiter settings and bucket as the testbench sees them
  logic [LVL_W-1:0]      lim_host_lo, lim_host_hi, lim_guest_lo, lim_guest_hi;
  logic [INTERVAL_W-1:0] lim_interval;
  logic [BURST_W-1:0]    lim_burst;
  logic [TOKEN_W-1:0]    bucket_tokens;
  logic [TIME_W-1:0]     bucket_last;
  logic [COUNT_W-1:0]    bucket_dropped;

  result_t   expected_verdicts[$];
  plan_row_t plan[$];

  int  n_errors = 0;
  int  n_msgs = 0;
  int  n_checked = 0;
  int  n_allowed = 0;
  int  n_reports = 0;
  int  n_settings = 0;
  int  idle_cycles = 0;
  int  rx_wait = 0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;

  log_level_rate_limiter_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pace(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic result_t decide_message(input req_t m);
    logic [LVL_W-1:0]   lvl, lo, hi;
    logic [TOKEN_W:0]   sum;
    logic [TOKEN_W-1:0] cap, elapsed;
    result_t            r;
    r = '0;
    lvl = m.has_level ? LVL_W'(m.level) : LVL_W'(DEFAULT_LEVEL);
    lo = m.from_guest ? lim_guest_lo : lim_host_lo;
    hi = m.from_guest ? lim_guest_hi : lim_host_hi;
    if (m.force_all || lvl < lo) begin
      r.allow = 1'b1;
    end else if (lvl < hi) begin
      elapsed = m.now_ms - bucket_last;
      sum = {1'b0, bucket_tokens} + {1'b0, elapsed};
      cap = TOKEN_W'(lim_burst) * TOKEN_W'(lim_interval);
      bucket_tokens = sum[TOKEN_W] ? '1 : sum[TOKEN_W-1:0];
      bucket_last = m.now_ms;
      if (bucket_tokens > cap) bucket_tokens = cap;
      if (bucket_tokens >= TOKEN_W'(lim_interval)) begin
        bucket_tokens = bucket_tokens - TOKEN_W'(lim_interval);
        r.allow = 1'b1;
        r.suppressed_count = bucket_dropped;
        bucket_dropped = '0;
      end else if (bucket_dropped != DROPPED_MAX) begin
        bucket_dropped = bucket_dropped + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic plan_row_t msg_row(input bit g, input bit h, input logic [1:0] l,
                                        input bit f, input logic [TIME_W-1:0] t,
                                        input bit typed = 1'b0, input bit a = 1'b0,
                                        input logic [COUNT_W-1:0] c = '0);
    plan_row_t row;
    row = '{default: '0};
    row.msg = '{from_guest: g, has_level: h, level: l, force_all: f, now_ms: t};
    row.typed = typed;
    row.want = '{allow: a, suppressed_count: c};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic logic [LVL_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return 4'd15;
      1: return LVL_W'($urandom_range(0, 15));
      default: return LVL_W'($urandom_range(0, 4));
    endcase
  endfunction

  // caller drops cfg_wr_en after the last write
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_HOST_LOWER:  lim_host_lo = val[LVL_W-1:0];
      REG_HOST_UPPER:  lim_host_hi = val[LVL_W-1:0];
      REG_GUEST_LOWER: lim_guest_lo = val[LVL_W-1:0];
      REG_GUEST_UPPER: lim_guest_hi = val[LVL_W-1:0];
      REG_INTERVAL:    lim_interval = val[INTERVAL_W-1:0];
      REG_BURST:       lim_burst = val[BURST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_request(input req_t m, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = pace(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_from_guest <= m.from_guest;
    in_has_level <= m.has_level;
    in_level <= m.level;
    in_force_all <= m.force_all;
    in_now_ms <= m.now_ms;
    do @(posedge clk); while (!in_ready);
    pred = decide_message(m);
    expected_verdicts.push_back(typed ? want : pred);
    n_msgs++;
  endtask

  // result side: check each verdict, then stall for a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else if (out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("verdict with nothing outstanding: allow %0d count %0d",
               out_allow, out_suppressed_count);
        n_errors++;
      end else begin
        result_t exp_v;
        exp_v = expected_verdicts.pop_front();
        if (out_allow !== exp_v.allow) begin
          $error("allow: expected %0d, actual %0d", exp_v.allow, out_allow);
          n_errors++;
        end
        if (out_suppressed_count !== exp_v.suppressed_count) begin
          $error("suppressed_count: expected %0d, actual %0d",
                 exp_v.suppressed_count, out_suppressed_count);
          n_errors++;
        end
        n_checked++;
        if (exp_v.allow) n_allowed++;
        if (exp_v.suppressed_count != 0) n_reports++;
      end
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      rx_wait = pace(rx_quiet);
      out_ready <= (rx_wait == 0);
    end else if (!out_ready) begin
      if (rx_wait > 0) rx_wait--;
      if (rx_wait == 0) out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
        $display("log_level_rate_limiter_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [TIME_W-1:0]     wall_ms;
    logic [LVL_W-1:0]      t_hl, t_hh, t_gl, t_gh;
    logic [INTERVAL_W-1:0] t_int;
    logic [BURST_W-1:0]    t_bst;
    req_t                  m;
    bit                    prev_cfg;

    lim_host_lo = HOST_LOWER_RST;
    lim_host_hi = HOST_UPPER_RST;
    lim_guest_lo = GUEST_LOWER_RST;
    lim_guest_hi = GUEST_UPPER_RST;
    lim_interval = INTERVAL_RST;
    lim_burst = BURST_RST;
    bucket_tokens = TOKENS_RST;
    bucket_last = '0;
    bucket_dropped = '0;

    // reset values: host 2/2, guest 0/2, 5000 ms, burst 10, 50000 tokens
    plan.push_back(msg_row(0, 1, 2'd0, 0, 32'd0, 1, 1, 0));      // under host lower
    plan.push_back(msg_row(0, 1, 2'd3, 0, 32'd0, 1, 0, 0));      // above host upper
    plan.push_back(msg_row(0, 0, 2'd3, 0, 32'd0, 1, 1, 0));      // no level -> 1
    plan.push_back(msg_row(0, 1, 2'd3, 1, 32'd0, 1, 1, 0));      // forced
    plan.push_back(msg_row(1, 1, 2'd3, 0, 32'd0, 1, 0, 0));
    plan.push_back(msg_row(1, 1, 2'd0, 0, 32'd0, 1, 1, 0));      // band, full bucket
    plan.push_back(cfg_row(REG_INTERVAL, 16'd20000));
    plan.push_back(msg_row(1, 0, 2'd0, 0, 32'd10));
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd10));
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd10));              // bucket empty
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd20));
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'hFFFF_FFFF));       // saturating refill
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd100));             // time wraps forward
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd50));              // time steps back
    plan.push_back(cfg_row(REG_INTERVAL, 16'hFFFF));
    plan.push_back(cfg_row(REG_BURST, 16'hFF00));                // burst 0, cap 0
    plan.push_back(cfg_row(REG_HOST_LOWER, 16'hFFF3));           // lower above upper
    plan.push_back(cfg_row(REG_HOST_UPPER, 16'h0001));
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd1000));
    plan.push_back(msg_row(0, 1, 2'd2, 0, 32'd1000, 1, 1, 0));
    plan.push_back(msg_row(0, 1, 2'd3, 0, 32'd1000, 1, 0, 0));
    plan.push_back(msg_row(1, 1, 2'd1, 1, 32'd1000, 1, 1, 0));
    plan.push_back(cfg_row(REG_BURST, 16'h00FF));
    plan.push_back(msg_row(1, 1, 2'd0, 0, 32'h8000_0000));       // reports one drop
    plan.push_back(cfg_row(REG_INTERVAL, 16'd0));
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd0));
    plan.push_back(cfg_row(REG_NONE_LO, 16'd0));                 // ignored
    plan.push_back(cfg_row(REG_NONE_HI, 16'hFFFF));              // ignored
    plan.push_back(msg_row(1, 1, 2'd1, 0, 32'd0));
    plan.push_back(cfg_row(REG_GUEST_LOWER, 16'h000F));
    plan.push_back(msg_row(1, 1, 2'd3, 0, 32'd5, 1, 1, 0));
    plan.push_back(cfg_row(REG_GUEST_LOWER, 16'h0000));
    plan.push_back(cfg_row(REG_GUEST_UPPER, 16'h0000));
    plan.push_back(msg_row(1, 1, 2'd0, 0, 32'd5, 1, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) begin
          settle();
          n_settings++;
        end
        program_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (prev_cfg) cfg_wr_en <= 1'b0;
        send_request(plan[i].msg, plan[i].typed, plan[i].want);
      end
      prev_cfg = plan[i].is_cfg;
    end

    wall_ms = 32'd7;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      n_settings++;
      case (ph)
        0: begin
          t_hl = 4'd0; t_hh = 4'd15; t_gl = 4'd15; t_gh = 4'd15;
          t_int = 16'hFFFF; t_bst = 8'hFF;
        end
        1: begin
          t_hl = 4'd1; t_hh = 4'd3; t_gl = 4'd0; t_gh = 4'd0;
          t_int = 16'd0; t_bst = 8'd0;
        end
        default: begin
          t_hl = pick_threshold();
          t_hh = pick_threshold();
          t_gl = pick_threshold();
          t_gh = pick_threshold();
          case ($urandom_range(0, 7))
            0: t_int = 16'd0;
            1: t_int = 16'hFFFF;
            2, 3: t_int = INTERVAL_W'($urandom_range(1, 20));
            4, 5: t_int = INTERVAL_W'($urandom_range(100, 5000));
            default: t_int = INTERVAL_W'($urandom);
          endcase
          case ($urandom_range(0, 7))
            0: t_bst = 8'd0;
            1: t_bst = 8'hFF;
            2: t_bst = BURST_W'($urandom);
            default: t_bst = BURST_W'($urandom_range(1, 8));
          endcase
        end
      endcase
      // upper data bits are junk for the narrow registers
      program_reg(REG_HOST_LOWER, {12'($urandom), t_hl});
      program_reg(REG_HOST_UPPER, {12'($urandom), t_hh});
      program_reg(REG_GUEST_LOWER, {12'($urandom), t_gl});
      program_reg(REG_GUEST_UPPER, {12'($urandom), t_gh});
      program_reg(REG_INTERVAL, t_int);
      program_reg(REG_BURST, {8'($urandom), t_bst});
      if ($urandom_range(0, 2) == 0)
        program_reg($urandom_range(0, 1) ? REG_NONE_LO : REG_NONE_HI, 16'($urandom));
      cfg_wr_en <= 1'b0;

      for (int k = 0; k < PHASE_MSGS; k++) begin
        // mostly time moving forward near the refill rate, sometimes jumps
        case ($urandom_range(0, 9))
          0: wall_ms = $urandom;
          1: wall_ms = wall_ms - $urandom_range(1, 1000);
          2: ;
          default: wall_ms = wall_ms + $urandom_range(0, 2 * int'(lim_interval) + 2);
        endcase
        m.from_guest = 1'($urandom_range(0, 1));
        m.has_level = ($urandom_range(0, 3) != 0);
        m.level = 2'($urandom_range(0, 3));
        m.force_all = ($urandom_range(0, 11) == 0);
        m.now_ms = wall_ms;
        send_request(m, 1'b0, '0);
      end
    end

    settle();
    $display("%0d messages under %0d settings, %0d verdicts checked",
             n_msgs, n_settings, n_checked);
    $display("%0d allowed, %0d carried a suppressed count", n_allowed, n_reports);
    if (n_errors == 0) begin
      $display("log_level_rate_limiter_top: match");
    end else begin
      $display("log_level_rate_limiter_top: mismatch");
    end
    $finish;
  end

endmodule
